// ===== rtl/tlvrcv_pkg.sv =====
`default_nettype none

package tlvrcv_pkg;

    localparam int POS_BITS = 24;
    localparam int LEN_BITS = 24;
    localparam int CMP_BITS = ((POS_BITS > LEN_BITS) ? POS_BITS : LEN_BITS) + 1;
    localparam int HDR_LEN_BITS = 32;
    localparam int HDR_CMP_BITS = HDR_LEN_BITS + 1;
    localparam int CNT_BITS = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] END_TAG = 32'hffffffff;
    localparam int HEADER_BYTES = 8;

    localparam logic [LEN_BITS-1:0] PAGE_LENGTH_RST = LEN_BITS'(4096);
    localparam logic [CNT_BITS-1:0] EXPECTED_RECORDS_RST = CNT_BITS'(1);
    localparam logic [31:0] FIRST_TAG_RST = 32'h00010002;
    localparam logic [LEN_BITS-1:0] FIRST_LENGTH_RST = LEN_BITS'(3288);
    localparam logic [31:0] EXPECTED_HASH_RST = 32'h1ac9054d;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PAGE_LENGTH = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPECTED_RECORDS = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_TAG = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_LENGTH = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPECTED_HASH = CFG_INDEX_BITS'(4);

    typedef enum logic [3:0] {
        ERR_NONE = 4'd0,
        ERR_SHORT_HEADER = 4'd1,
        ERR_BAD_LENGTH = 4'd2,
        ERR_BAD_FIRST = 4'd3,
        ERR_REPEAT_FIRST = 4'd4,
        ERR_BAD_TERMINAL = 4'd5,
        ERR_TOO_MANY = 4'd6,
        ERR_COUNT_OR_TERMINAL = 4'd7,
        ERR_HASH_MISMATCH = 4'd8
    } err_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] page_length;
        logic [CNT_BITS-1:0] expected_records;
        logic [31:0] first_tag;
        logic [LEN_BITS-1:0] first_length;
        logic [31:0] expected_hash;
    } cfg_t;

    typedef struct packed {
        logic last;
        err_t err;
        logic [CNT_BITS-1:0] records;
    } parse_res_t;

endpackage

`default_nettype wire

// ===== rtl/tlvrcv_parser.sv =====
`default_nettype none

module tlvrcv_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire logic [7:0]          page_byte,
    input  wire tlvrcv_pkg::cfg_t    cfg,
    input  wire logic                hash_match,
    output tlvrcv_pkg::parse_res_t   res
);

    localparam int PB = tlvrcv_pkg::POS_BITS;
    localparam int CB = tlvrcv_pkg::CMP_BITS;
    localparam int HB = tlvrcv_pkg::HDR_CMP_BITS;
    localparam int NB = tlvrcv_pkg::CNT_BITS;

    function automatic logic [CB-1:0] left_from(
        input logic [tlvrcv_pkg::LEN_BITS-1:0] plen,
        input logic [PB-1:0] x
    );
        logic [CB-1:0] pl;
        logic [CB-1:0] xx;
        pl = CB'(plen);
        xx = CB'(x);
        left_from = (pl > xx) ? (pl - xx) : '0;
    endfunction

    logic [PB-1:0] pos_reg, pos_next;
    logic [PB-1:0] start_reg, start_next;
    logic [PB-1:0] left_reg, left_next;
    logic [63:0] shift_reg, shift_next;
    logic [NB-1:0] count_reg, count_next;
    logic term_reg, term_next;
    tlvrcv_pkg::err_t err_reg, err_next;

    logic [PB-1:0] start_p, left_p, pos_plus1, k, left_len;
    logic [63:0] shift_p;
    logic [NB-1:0] count_p;
    logic term_p;
    tlvrcv_pkg::err_t err_p, err_f;
    logic [31:0] tag, len;
    logic last;

    always_comb
    begin
        pos_plus1 = pos_reg + PB'(1);
        last = (CB'(pos_reg) + CB'(1)) >= CB'(cfg.page_length);
        k = pos_reg - start_reg;
        start_p = start_reg;
        left_p = left_reg;
        shift_p = shift_reg;
        count_p = count_reg;
        term_p = term_reg;
        err_p = err_reg;
        tag = '0;
        len = '0;
        left_len = '0;

        if (err_reg == tlvrcv_pkg::ERR_NONE)
        begin
            if (left_reg != '0)
            begin
                left_p = left_reg - PB'(1);
                if (left_reg == PB'(1))
                begin
                    start_p = pos_plus1;
                end
            end
            else if (k == '0 && left_from(cfg.page_length, pos_reg) <
                     CB'(tlvrcv_pkg::HEADER_BYTES))
            begin
                err_p = tlvrcv_pkg::ERR_SHORT_HEADER;
            end
            else
            begin
                shift_p = {shift_reg[55:0], page_byte};
                tag = shift_p[63:32];
                len = shift_p[31:0];
                left_len = len[PB-1:0] - PB'(tlvrcv_pkg::HEADER_BYTES);
                if (k >= PB'(7))
                begin
                    if (len < 32'(tlvrcv_pkg::HEADER_BYTES) ||
                        HB'(len) > HB'(left_from(cfg.page_length, start_reg)))
                    begin
                        err_p = tlvrcv_pkg::ERR_BAD_LENGTH;
                    end
                    else if (count_reg == '0 &&
                             (tag != cfg.first_tag || len != 32'(cfg.first_length)))
                    begin
                        err_p = tlvrcv_pkg::ERR_BAD_FIRST;
                    end
                    else if (count_reg != '0 && tag == cfg.first_tag)
                    begin
                        err_p = tlvrcv_pkg::ERR_REPEAT_FIRST;
                    end
                    else if (tag == tlvrcv_pkg::END_TAG &&
                             (len != 32'(tlvrcv_pkg::HEADER_BYTES) ||
                              CB'(cfg.page_length) < CB'(tlvrcv_pkg::HEADER_BYTES) ||
                              CB'(start_reg) != CB'(cfg.page_length) -
                                                CB'(tlvrcv_pkg::HEADER_BYTES)))
                    begin
                        err_p = tlvrcv_pkg::ERR_BAD_TERMINAL;
                    end
                    else if (count_reg >= cfg.expected_records)
                    begin
                        err_p = tlvrcv_pkg::ERR_TOO_MANY;
                        if (tag == tlvrcv_pkg::END_TAG)
                        begin
                            term_p = 1'b1;
                        end
                    end
                    else
                    begin
                        if (tag == tlvrcv_pkg::END_TAG)
                        begin
                            term_p = 1'b1;
                        end
                        if (count_reg != {NB{1'b1}})
                        begin
                            count_p = count_reg + NB'(1);
                        end
                        left_p = left_len;
                        if (left_len == '0)
                        begin
                            start_p = pos_plus1;
                        end
                    end
                end
            end
        end

        err_f = err_p;
        if (err_p == tlvrcv_pkg::ERR_NONE)
        begin
            if (left_p == '0 && (pos_plus1 - start_p) != '0)
            begin
                err_f = tlvrcv_pkg::ERR_SHORT_HEADER;
            end
            else if (left_p != '0)
            begin
                err_f = tlvrcv_pkg::ERR_BAD_LENGTH;
            end
            else if (!term_p || count_p != cfg.expected_records)
            begin
                err_f = tlvrcv_pkg::ERR_COUNT_OR_TERMINAL;
            end
            else if (!hash_match)
            begin
                err_f = tlvrcv_pkg::ERR_HASH_MISMATCH;
            end
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        start_next = start_reg;
        left_next = left_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        term_next = term_reg;
        err_next = err_reg;
        if (take)
        begin
            if (last)
            begin
                pos_next = '0;
                start_next = '0;
                left_next = '0;
                shift_next = '0;
                count_next = '0;
                term_next = 1'b0;
                err_next = tlvrcv_pkg::ERR_NONE;
            end
            else
            begin
                pos_next = pos_plus1;
                start_next = start_p;
                left_next = left_p;
                shift_next = shift_p;
                count_next = count_p;
                term_next = term_p;
                err_next = err_p;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            start_reg <= '0;
            left_reg <= '0;
            shift_reg <= '0;
            count_reg <= '0;
            term_reg <= 1'b0;
            err_reg <= tlvrcv_pkg::ERR_NONE;
        end
        else
        begin
            pos_reg <= pos_next;
            start_reg <= start_next;
            left_reg <= left_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            term_reg <= term_next;
            err_reg <= err_next;
        end
    end

    assign res.last = last;
    assign res.err = err_f;
    assign res.records = count_p;

endmodule

`default_nettype wire

// ===== rtl/tlv_record_chain_validator_top.sv =====
`default_nettype none

// Checks a page of TLV records streamed one byte per cycle: unless in_stall
// is high, a new byte can be taken every clock, since each byte's header parse
// and FNV-1a step are logic between the parse state and result registers. A page
// is page_length bytes; its last byte produces exactly one result (page_ok,
// error_code, page_hash, records_seen) in the cycle after it is taken, and the
// block then starts over for the next page. Earlier bytes produce nothing.
// The first error of a page is held; hashing continues to the end. The result
// register lets the next page stream in while a result waits on out_stall;
// only that page's last byte is held off until the waiting result leaves.
// Write the registers only while no page is in progress.
module tlv_record_chain_validator_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output      logic                                  in_stall,
    input  wire logic [7:0]                            page_byte,
    output      logic                                  out_valid,
    input  wire logic                                  out_stall,
    output      logic                                  page_ok,
    output      logic [3:0]                            error_code,
    output      logic [31:0]                           page_hash,
    output      logic [tlvrcv_pkg::CNT_BITS-1:0]       records_seen,
    input  wire logic                                  cfg_valid,
    output      logic                                  cfg_ready,
    input  wire logic [tlvrcv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [tlvrcv_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        fnv_step = x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
    endfunction

    logic [tlvrcv_pkg::LEN_BITS-1:0] page_length_reg;
    logic [tlvrcv_pkg::CNT_BITS-1:0] expected_records_reg;
    logic [31:0] first_tag_reg;
    logic [tlvrcv_pkg::LEN_BITS-1:0] first_length_reg;
    logic [31:0] expected_hash_reg;
    tlvrcv_pkg::cfg_t cfg;

    logic [31:0] hash_reg, hash_next, hash_step;
    logic take;
    tlvrcv_pkg::parse_res_t res;

    logic out_valid_reg, out_valid_next;
    logic ok_reg, ok_next;
    logic [3:0] code_reg, code_next;
    logic [31:0] phash_reg, phash_next;
    logic [tlvrcv_pkg::CNT_BITS-1:0] recs_reg, recs_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_length_reg <= tlvrcv_pkg::PAGE_LENGTH_RST;
            expected_records_reg <= tlvrcv_pkg::EXPECTED_RECORDS_RST;
            first_tag_reg <= tlvrcv_pkg::FIRST_TAG_RST;
            first_length_reg <= tlvrcv_pkg::FIRST_LENGTH_RST;
            expected_hash_reg <= tlvrcv_pkg::EXPECTED_HASH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tlvrcv_pkg::REG_PAGE_LENGTH:
                    page_length_reg <= cfg_data[tlvrcv_pkg::LEN_BITS-1:0];
                tlvrcv_pkg::REG_EXPECTED_RECORDS:
                    expected_records_reg <= cfg_data[tlvrcv_pkg::CNT_BITS-1:0];
                tlvrcv_pkg::REG_FIRST_TAG:
                    first_tag_reg <= cfg_data[31:0];
                tlvrcv_pkg::REG_FIRST_LENGTH:
                    first_length_reg <= cfg_data[tlvrcv_pkg::LEN_BITS-1:0];
                tlvrcv_pkg::REG_EXPECTED_HASH:
                    expected_hash_reg <= cfg_data[31:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg.page_length = page_length_reg;
    assign cfg.expected_records = expected_records_reg;
    assign cfg.first_tag = first_tag_reg;
    assign cfg.first_length = first_length_reg;
    assign cfg.expected_hash = expected_hash_reg;

    assign in_stall = out_valid_reg && out_stall && res.last;
    assign take = in_valid && !in_stall;
    assign hash_step = fnv_step(hash_reg, page_byte);

    tlvrcv_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .page_byte  (page_byte),
        .cfg        (cfg),
        .hash_match (hash_step == expected_hash_reg),
        .res        (res)
    );

    always_comb
    begin
        hash_next = hash_reg;
        out_valid_next = out_valid_reg;
        ok_next = ok_reg;
        code_next = code_reg;
        phash_next = phash_reg;
        recs_next = recs_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            hash_next = res.last ? tlvrcv_pkg::FNV_BASIS : hash_step;
            if (res.last)
            begin
                out_valid_next = 1'b1;
                ok_next = (res.err == tlvrcv_pkg::ERR_NONE);
                code_next = res.err;
                phash_next = hash_step;
                recs_next = res.records;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= tlvrcv_pkg::FNV_BASIS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hash_reg <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
        code_reg <= code_next;
        phash_reg <= phash_next;
        recs_reg <= recs_next;
    end

    assign out_valid = out_valid_reg;
    assign page_ok = ok_reg;
    assign error_code = code_reg;
    assign page_hash = phash_reg;
    assign records_seen = recs_reg;

endmodule

`default_nettype wire
